>>> rtl/bctd_pkg.sv
// bctd_pkg: shared constants and types for the battery charge trend detector
// used by the channel interfaces, the update logic and the top level
package bctd_pkg;

    localparam int VOLT_WIDTH = 13;
    localparam int RUN_WIDTH  = 8;

    localparam int THR_WIDTH   = 10;
    localparam int COUNT_WIDTH = 8;
    localparam int VBUS_WIDTH  = 14;
    localparam int VP_WIDTH    = 13;
    localparam int LEVEL_WIDTH = 8;
    localparam int CFG_WIDTH   = 13;
    localparam int CFG_IDX_WIDTH = 2;

    localparam int unsigned DEAD_BAND_MV = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_TREND_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CONFIRM_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CLEAR_SAMPLES   = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_VBUS_PRESENT    = 2'd3;

    localparam logic [THR_WIDTH-1:0]   RST_TREND_THRESHOLD = 10'd20;
    localparam logic [COUNT_WIDTH-1:0] RST_CONFIRM_SAMPLES = 8'd3;
    localparam logic [COUNT_WIDTH-1:0] RST_CLEAR_SAMPLES   = 8'd3;
    localparam logic [VP_WIDTH-1:0]    RST_VBUS_PRESENT    = 13'd4000;

    localparam logic [1:0] CHG_CHARGING = 2'd1;

    typedef struct packed {
        logic [THR_WIDTH-1:0]   trend_threshold_mv;
        logic [COUNT_WIDTH-1:0] confirm_samples;
        logic [COUNT_WIDTH-1:0] clear_samples;
        logic [VP_WIDTH-1:0]    vbus_present_mv;
    } t_cfg;

endpackage

>>> rtl/bctd_in_if.sv
// bctd_in_if: sample channel, valid/ready with one power sample as payload
// depends on bctd_pkg for widths
interface bctd_in_if #(
    parameter int VOLT_WIDTH = bctd_pkg::VOLT_WIDTH
);
    logic                                     valid;
    logic                                     ready;
    logic [VOLT_WIDTH-1:0]                    battery_mv;
    logic signed [bctd_pkg::LEVEL_WIDTH-1:0]  battery_level;
    logic signed [bctd_pkg::VBUS_WIDTH-1:0]   vbus_mv;
    logic [1:0]                               reported_charging;

    modport source (
        output valid, battery_mv, battery_level, vbus_mv, reported_charging,
        input  ready
    );
    modport sink (
        input  valid, battery_mv, battery_level, vbus_mv, reported_charging,
        output ready
    );
endinterface

>>> rtl/bctd_out_if.sv
// bctd_out_if: result channel, valid/ready with the filtered status and trend deltas
// depends on bctd_pkg for widths
interface bctd_out_if #(
    parameter int VOLT_WIDTH = bctd_pkg::VOLT_WIDTH
);
    logic                                     valid;
    logic                                     ready;
    logic                                     filtered_charging;
    logic                                     level_displayable;
    logic                                     trend_valid;
    logic [VOLT_WIDTH-1:0]                    trend_rise_mv;
    logic                                     level_delta_valid;
    logic signed [bctd_pkg::LEVEL_WIDTH-1:0]  level_change;

    modport source (
        output valid, filtered_charging, level_displayable, trend_valid,
               trend_rise_mv, level_delta_valid, level_change,
        input  ready
    );
    modport sink (
        input  valid, filtered_charging, level_displayable, trend_valid,
               trend_rise_mv, level_delta_valid, level_change,
        output ready
    );
endinterface

>>> rtl/battery_charge_trend_detector.sv
// battery_charge_trend_detector: infers charging from the battery voltage trend
// depends on bctd_pkg, bctd_in_if, bctd_out_if and bctd_update
//
// usage
//   i_in carries one power sample per transfer: battery mV (0 = no reading,
//   the window is left alone), level percent, VBUS mV and the gauge flag.
//   o_out carries one result per sample: filtered charging, level
//   displayable, trend valid, rise over the window minimum and level change.
//   configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must write it only while no sample is in flight, the block does not enforce this.
// latency and throughput
//   a result appears in the cycle after its sample transfer; one sample per
//   cycle is taken unless o_out stalls, set by the single result register.
// reset
//   synchronous, active low; clears the window and runs and loads the
//   default configuration.
// stall
//   while a result waits on o_out.ready, i_in.ready stays low unless the
//   waiting result is taken in the same cycle.
module battery_charge_trend_detector #(
    parameter int VOLT_WIDTH = bctd_pkg::VOLT_WIDTH,
    parameter int RUN_WIDTH  = bctd_pkg::RUN_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bctd_in_if.sink                             i_in,
    bctd_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [bctd_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [bctd_pkg::CFG_WIDTH-1:0]      i_cfg_data
);
    localparam int LW = bctd_pkg::LEVEL_WIDTH;

    bctd_pkg::t_cfg r_cfg;

    logic                  r_started;
    logic [VOLT_WIDTH-1:0] r_last_v;
    logic [VOLT_WIDTH-1:0] r_low_v;
    logic [VOLT_WIDTH-1:0] r_high_v;
    logic signed [LW-1:0]  r_first_lvl;
    logic signed [LW-1:0]  r_last_lvl;
    logic [RUN_WIDTH-1:0]  r_fall_run;
    logic [RUN_WIDTH-1:0]  r_above_run;
    logic                  r_inferred;

    logic                  n_started;
    logic [VOLT_WIDTH-1:0] n_last_v;
    logic [VOLT_WIDTH-1:0] n_low_v;
    logic [VOLT_WIDTH-1:0] n_high_v;
    logic signed [LW-1:0]  n_first_lvl;
    logic signed [LW-1:0]  n_last_lvl;
    logic [RUN_WIDTH-1:0]  n_fall_run;
    logic [RUN_WIDTH-1:0]  n_above_run;
    logic                  n_inferred;

    logic                  n_filtered;
    logic                  n_displayable;
    logic                  n_tvalid;
    logic [VOLT_WIDTH-1:0] n_rise;
    logic                  n_dvalid;
    logic signed [LW-1:0]  n_change;

    logic                  r_out_valid;
    logic                  r_filtered;
    logic                  r_displayable;
    logic                  r_tvalid;
    logic [VOLT_WIDTH-1:0] r_rise;
    logic                  r_dvalid;
    logic signed [LW-1:0]  r_change;

    logic in_xfer;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    bctd_update #(
        .VOLT_WIDTH (VOLT_WIDTH),
        .RUN_WIDTH  (RUN_WIDTH)
    ) u_update (
        .i_cfg         (r_cfg),
        .i_v           (i_in.battery_mv),
        .i_level       (i_in.battery_level),
        .i_vbus        (i_in.vbus_mv),
        .i_rc          (i_in.reported_charging),
        .i_started     (r_started),
        .i_last_v      (r_last_v),
        .i_low_v       (r_low_v),
        .i_high_v      (r_high_v),
        .i_first_lvl   (r_first_lvl),
        .i_last_lvl    (r_last_lvl),
        .i_fall_run    (r_fall_run),
        .i_above_run   (r_above_run),
        .i_inferred    (r_inferred),
        .o_started     (n_started),
        .o_last_v      (n_last_v),
        .o_low_v       (n_low_v),
        .o_high_v      (n_high_v),
        .o_first_lvl   (n_first_lvl),
        .o_last_lvl    (n_last_lvl),
        .o_fall_run    (n_fall_run),
        .o_above_run   (n_above_run),
        .o_inferred    (n_inferred),
        .o_filtered    (n_filtered),
        .o_displayable (n_displayable),
        .o_tvalid      (n_tvalid),
        .o_rise        (n_rise),
        .o_dvalid      (n_dvalid),
        .o_change      (n_change)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trend_threshold_mv <= bctd_pkg::RST_TREND_THRESHOLD;
            r_cfg.confirm_samples    <= bctd_pkg::RST_CONFIRM_SAMPLES;
            r_cfg.clear_samples      <= bctd_pkg::RST_CLEAR_SAMPLES;
            r_cfg.vbus_present_mv    <= bctd_pkg::RST_VBUS_PRESENT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bctd_pkg::REG_TREND_THRESHOLD: begin
                    r_cfg.trend_threshold_mv <= i_cfg_data[bctd_pkg::THR_WIDTH-1:0];
                end
                bctd_pkg::REG_CONFIRM_SAMPLES: begin
                    r_cfg.confirm_samples <= i_cfg_data[bctd_pkg::COUNT_WIDTH-1:0];
                end
                bctd_pkg::REG_CLEAR_SAMPLES: begin
                    r_cfg.clear_samples <= i_cfg_data[bctd_pkg::COUNT_WIDTH-1:0];
                end
                bctd_pkg::REG_VBUS_PRESENT: begin
                    r_cfg.vbus_present_mv <= i_cfg_data[bctd_pkg::VP_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_last_v    <= '0;
            r_low_v     <= '0;
            r_high_v    <= '0;
            r_first_lvl <= '0;
            r_last_lvl  <= '0;
            r_fall_run  <= '0;
            r_above_run <= '0;
            r_inferred  <= 1'b0;
        end else if (in_xfer) begin
            r_started   <= n_started;
            r_last_v    <= n_last_v;
            r_low_v     <= n_low_v;
            r_high_v    <= n_high_v;
            r_first_lvl <= n_first_lvl;
            r_last_lvl  <= n_last_lvl;
            r_fall_run  <= n_fall_run;
            r_above_run <= n_above_run;
            r_inferred  <= n_inferred;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_filtered    <= n_filtered;
            r_displayable <= n_displayable;
            r_tvalid      <= n_tvalid;
            r_rise        <= n_rise;
            r_dvalid      <= n_dvalid;
            r_change      <= n_change;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.filtered_charging = r_filtered;
    assign o_out.level_displayable = r_displayable;
    assign o_out.trend_valid       = r_tvalid;
    assign o_out.trend_rise_mv     = r_rise;
    assign o_out.level_delta_valid = r_dvalid;
    assign o_out.level_change      = r_change;

endmodule

>>> rtl/bctd_update.sv
// bctd_update: next trend window state and result fields for one sample
// combinational, depends on bctd_pkg
module bctd_update #(
    parameter int VOLT_WIDTH = bctd_pkg::VOLT_WIDTH,
    parameter int RUN_WIDTH  = bctd_pkg::RUN_WIDTH
) (
    input  bctd_pkg::t_cfg                          i_cfg,
    input  logic [VOLT_WIDTH-1:0]                   i_v,
    input  logic signed [bctd_pkg::LEVEL_WIDTH-1:0] i_level,
    input  logic signed [bctd_pkg::VBUS_WIDTH-1:0]  i_vbus,
    input  logic [1:0]                              i_rc,
    input  logic                                    i_started,
    input  logic [VOLT_WIDTH-1:0]                   i_last_v,
    input  logic [VOLT_WIDTH-1:0]                   i_low_v,
    input  logic [VOLT_WIDTH-1:0]                   i_high_v,
    input  logic signed [bctd_pkg::LEVEL_WIDTH-1:0] i_first_lvl,
    input  logic signed [bctd_pkg::LEVEL_WIDTH-1:0] i_last_lvl,
    input  logic [RUN_WIDTH-1:0]                    i_fall_run,
    input  logic [RUN_WIDTH-1:0]                    i_above_run,
    input  logic                                    i_inferred,
    output logic                                    o_started,
    output logic [VOLT_WIDTH-1:0]                   o_last_v,
    output logic [VOLT_WIDTH-1:0]                   o_low_v,
    output logic [VOLT_WIDTH-1:0]                   o_high_v,
    output logic signed [bctd_pkg::LEVEL_WIDTH-1:0] o_first_lvl,
    output logic signed [bctd_pkg::LEVEL_WIDTH-1:0] o_last_lvl,
    output logic [RUN_WIDTH-1:0]                    o_fall_run,
    output logic [RUN_WIDTH-1:0]                    o_above_run,
    output logic                                    o_inferred,
    output logic                                    o_filtered,
    output logic                                    o_displayable,
    output logic                                    o_tvalid,
    output logic [VOLT_WIDTH-1:0]                   o_rise,
    output logic                                    o_dvalid,
    output logic signed [bctd_pkg::LEVEL_WIDTH-1:0] o_change
);
    localparam int CW = (RUN_WIDTH > bctd_pkg::COUNT_WIDTH) ? RUN_WIDTH
                                                            : bctd_pkg::COUNT_WIDTH;
    localparam logic [VOLT_WIDTH:0] DB = (VOLT_WIDTH+1)'(bctd_pkg::DEAD_BAND_MV);

    logic [VOLT_WIDTH:0]   v_ext;
    logic [VOLT_WIDTH:0]   last_ext;
    logic [VOLT_WIDTH-1:0] thr;
    logic [VOLT_WIDTH-1:0] low_t;
    logic [VOLT_WIDTH-1:0] high_t;
    logic [RUN_WIDTH-1:0]  fall_t;
    logic [RUN_WIDTH-1:0]  above_t;
    logic                  inferred_t;
    logic                  drop;
    logic                  above;
    logic                  nonzero;
    logic                  vbus_ok;

    always_comb begin
        v_ext    = {1'b0, i_v};
        last_ext = {1'b0, i_last_v};
        thr      = VOLT_WIDTH'(i_cfg.trend_threshold_mv);
        nonzero  = (i_v != '0);

        // falling run with dead band
        if (v_ext > last_ext + DB) begin
            fall_t = '0;
        end else if (v_ext + DB < last_ext) begin
            fall_t = (i_fall_run == '1) ? i_fall_run : i_fall_run + 1'b1;
        end else begin
            fall_t = i_fall_run;
        end

        low_t  = (i_v < i_low_v) ? i_v : i_low_v;
        high_t = (i_v > i_high_v) ? i_v : i_high_v;

        drop  = (CW'(fall_t) >= CW'(i_cfg.clear_samples)) && ((high_t - i_v) > thr);
        above = (i_v - low_t) > thr;

        above_t    = above ? ((i_above_run == '1) ? i_above_run : i_above_run + 1'b1)
                           : '0;
        inferred_t = above ? i_inferred : 1'b0;
        if (CW'(above_t) >= CW'(i_cfg.confirm_samples)) begin
            inferred_t = 1'b1;
        end

        o_started   = i_started;
        o_last_v    = i_last_v;
        o_low_v     = i_low_v;
        o_high_v    = i_high_v;
        o_first_lvl = i_first_lvl;
        o_last_lvl  = i_last_lvl;
        o_fall_run  = i_fall_run;
        o_above_run = i_above_run;
        o_inferred  = i_inferred;

        if (nonzero) begin
            o_last_v   = i_v;
            o_last_lvl = i_level;
            if (!i_started) begin
                // first sample seeds the window
                o_started   = 1'b1;
                o_low_v     = i_v;
                o_high_v    = i_v;
                o_first_lvl = i_level;
            end else if (drop) begin
                // confirmed drop from peak re-bases the window
                o_low_v     = i_v;
                o_high_v    = i_v;
                o_first_lvl = i_level;
                o_fall_run  = '0;
                o_above_run = '0;
                o_inferred  = 1'b0;
            end else begin
                o_low_v     = low_t;
                o_high_v    = high_t;
                o_fall_run  = fall_t;
                o_above_run = above_t;
                o_inferred  = inferred_t;
            end
        end

        vbus_ok = i_vbus >= $signed({1'b0, i_cfg.vbus_present_mv});
        o_filtered    = vbus_ok && o_started && o_inferred;
        o_displayable = !i_level[bctd_pkg::LEVEL_WIDTH-1]
                        && !((i_rc == bctd_pkg::CHG_CHARGING) && !o_filtered);
        o_tvalid      = o_started && nonzero;
        o_rise        = o_tvalid ? (o_last_v - o_low_v) : '0;
        o_dvalid      = o_tvalid && !i_level[bctd_pkg::LEVEL_WIDTH-1]
                        && !o_first_lvl[bctd_pkg::LEVEL_WIDTH-1];
        o_change      = o_dvalid ? (o_last_lvl - o_first_lvl) : '0;
    end

endmodule

>>> dv/tb_battery_charge_trend_detector.sv
// testbench for battery_charge_trend_detector: directed samples, long voltage ramps
// and random trend sequences, checked against an in-bench window model or, for
// typed rows, fixed wants; depends on bctd_pkg, bctd_in_if, bctd_out_if, rtl top level
module tb_battery_charge_trend_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOLT_WIDTH    = bctd_pkg::VOLT_WIDTH;
    localparam int RUN_WIDTH     = bctd_pkg::RUN_WIDTH;
    localparam int LEVEL_WIDTH   = bctd_pkg::LEVEL_WIDTH;
    localparam int VBUS_WIDTH    = bctd_pkg::VBUS_WIDTH;
    localparam int CFG_IDX_WIDTH = bctd_pkg::CFG_IDX_WIDTH;
    localparam int CFG_WIDTH     = bctd_pkg::CFG_WIDTH;
    localparam int THR_WIDTH     = bctd_pkg::THR_WIDTH;
    localparam int COUNT_WIDTH   = bctd_pkg::COUNT_WIDTH;
    localparam int VP_WIDTH      = bctd_pkg::VP_WIDTH;

    localparam int unsigned RUN_MAX     = (1 << RUN_WIDTH) - 1;
    localparam int          CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [VOLT_WIDTH-1:0]         mv;
        logic signed [LEVEL_WIDTH-1:0] level;
        logic signed [VBUS_WIDTH-1:0]  vbus;
        logic [1:0]                    rc;
    } t_power_sample;

    typedef struct packed {
        logic                          filt;
        logic                          disp;
        logic                          tvalid;
        logic [VOLT_WIDTH-1:0]         rise;
        logic                          dvalid;
        logic signed [LEVEL_WIDTH-1:0] change;
    } t_status;

    typedef struct packed {
        bit            typed;
        t_power_sample s;
        t_status       want;
    } t_directed_row;

    typedef enum {SEQ_MIXED, SEQ_RISE, SEQ_FALL} t_seq_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [CFG_WIDTH-1:0]     i_cfg_data;

    bctd_in_if  in_if ();
    bctd_out_if out_if ();

    battery_charge_trend_detector uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // window model
    bctd_pkg::t_cfg cfg_model = '{bctd_pkg::RST_TREND_THRESHOLD, bctd_pkg::RST_CONFIRM_SAMPLES,
                                  bctd_pkg::RST_CLEAR_SAMPLES, bctd_pkg::RST_VBUS_PRESENT};
    bit          w_started = 1'b0;
    bit          w_inferred = 1'b0;
    int unsigned w_last_mv = 0;
    int unsigned w_low_mv = 0;
    int unsigned w_high_mv = 0;
    int unsigned w_fall_run = 0;
    int unsigned w_above_run = 0;
    int          w_first_level = 0;
    int          w_last_level = 0;

    t_status pending_status[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      idle_on = 1'b1;
    int      hold_request = 0;

    // sequence generator state
    int cur_mv = 3700;
    int cur_level = 50;
    int seg_left = 0;
    int seg_step = 0;

    t_directed_row directed_rows [19] = '{
        '{1'b1, '{13'd0,    8'hFF,   14'h3FFF,  2'd3}, '{1'b0, 1'b0, 1'b0, 13'd0, 1'b0, 8'd0}},
        '{1'b1, '{13'd8191, 8'd100,  14'd8191,  2'd1}, '{1'b0, 1'b0, 1'b1, 13'd0, 1'b1, 8'd0}},
        '{1'b0, '{13'd1,    8'd0,    14'd0,     2'd0}, '0},
        '{1'b0, '{13'd100,  8'd50,   14'd4000,  2'd1}, '0},
        '{1'b0, '{13'd200,  8'd51,   14'd4000,  2'd1}, '0},
        '{1'b0, '{13'd300,  8'd52,   14'd4000,  2'd1}, '0},
        '{1'b0, '{13'd301,  8'd53,   14'd3999,  2'd1}, '0},
        '{1'b0, '{13'd0,    8'd53,   14'd5000,  2'd2}, '0},
        '{1'b0, '{13'd290,  8'hFF,   14'd5000,  2'd0}, '0},
        '{1'b0, '{13'd280,  8'd60,   14'd5000,  2'd1}, '0},
        '{1'b0, '{13'd270,  8'd60,   14'd5000,  2'd1}, '0},
        '{1'b0, '{13'd272,  8'd61,   14'd4000,  2'd3}, '0},
        '{1'b0, '{13'd268,  8'h80,   14'h2000,  2'd1}, '0},
        '{1'b0, '{13'd8191, 8'd127,  14'd8191,  2'd2}, '0},
        '{1'b0, '{13'd8190, 8'd127,  14'd4000,  2'd0}, '0},
        '{1'b1, '{13'd0,    8'hFF,   14'h3FFF,  2'd0}, '{1'b0, 1'b0, 1'b0, 13'd0, 1'b0, 8'd0}},
        '{1'b0, '{13'd4096, 8'd100,  14'd8191,  2'd1}, '0},
        '{1'b0, '{13'd2048, 8'd0,    14'd0,     2'd3}, '0},
        '{1'b0, '{13'd1024, 8'd100,  14'h3FFF,  2'd1}, '0}
    };

    function automatic t_status predict_status(input t_power_sample s);
        int unsigned v;
        int          level;
        int          vbus;
        t_status     r;
        v = s.mv;
        level = $signed(s.level);
        vbus = $signed(s.vbus);
        if (v != 0) begin
            if (!w_started) begin
                w_started = 1'b1;
                w_last_mv = v;
                w_low_mv = v;
                w_high_mv = v;
                w_first_level = level;
                w_last_level = level;
            end else begin
                if (v > w_last_mv + bctd_pkg::DEAD_BAND_MV) begin
                    w_fall_run = 0;
                end else if (v + bctd_pkg::DEAD_BAND_MV < w_last_mv &&
                             w_fall_run < RUN_MAX) begin
                    w_fall_run++;
                end
                w_last_mv = v;
                w_last_level = level;
                if (v < w_low_mv) w_low_mv = v;
                if (v > w_high_mv) w_high_mv = v;
                // confirmed drop from the peak re-bases the window
                if (w_fall_run >= cfg_model.clear_samples &&
                    w_high_mv - w_last_mv > cfg_model.trend_threshold_mv) begin
                    w_low_mv = v;
                    w_high_mv = v;
                    w_first_level = level;
                    w_fall_run = 0;
                    w_above_run = 0;
                    w_inferred = 1'b0;
                end else begin
                    if (w_last_mv - w_low_mv > cfg_model.trend_threshold_mv) begin
                        if (w_above_run < RUN_MAX) w_above_run++;
                    end else begin
                        w_above_run = 0;
                        w_inferred = 1'b0;
                    end
                    if (w_above_run >= cfg_model.confirm_samples) w_inferred = 1'b1;
                end
            end
        end
        r = '0;
        r.filt = vbus >= int'(cfg_model.vbus_present_mv) && w_started && w_inferred;
        r.disp = level >= 0 && !(s.rc == bctd_pkg::CHG_CHARGING && !r.filt);
        r.tvalid = w_started && v != 0;
        if (r.tvalid) r.rise = VOLT_WIDTH'(w_last_mv - w_low_mv);
        r.dvalid = r.tvalid && level >= 0 && w_first_level >= 0;
        if (r.dvalid) r.change = LEVEL_WIDTH'(w_last_level - w_first_level);
        return r;
    endfunction

    function automatic t_power_sample next_sample(input t_seq_mode mode);
        t_power_sample s;
        int            pick;
        case (mode)
            SEQ_RISE: cur_mv += int'($urandom_range(3, 5));
            SEQ_FALL: cur_mv -= int'($urandom_range(3, 4));
            default: begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(2, 14);
                    case ($urandom_range(0, 3))
                        0: seg_step = int'($urandom_range(3, 40));
                        1: seg_step = -int'($urandom_range(3, 40));
                        2: seg_step = 0;
                        default: seg_step = int'($urandom_range(0, 6)) - 3;
                    endcase
                end
                seg_left--;
                cur_mv += seg_step + int'($urandom_range(0, 4)) - 2;
            end
        endcase
        if (cur_mv < 1) cur_mv = 1;
        if (cur_mv > 8191) cur_mv = 8191;
        pick = $urandom_range(0, 19);
        if (pick == 0) s.mv = '0;
        else if (pick == 1 && mode == SEQ_MIXED) s.mv = VOLT_WIDTH'($urandom_range(1, 8191));
        else s.mv = VOLT_WIDTH'(cur_mv);

        cur_level += int'($urandom_range(0, 2)) - 1;
        if (cur_level < 0) cur_level = 0;
        if (cur_level > 100) cur_level = 100;
        pick = $urandom_range(0, 9);
        if (pick == 0) s.level = '1;
        else if (pick == 1) s.level = LEVEL_WIDTH'($urandom);
        else s.level = LEVEL_WIDTH'(cur_level);

        case ($urandom_range(0, 5))
            0: s.vbus = '1;
            1: s.vbus = VBUS_WIDTH'($urandom);
            2: s.vbus = VBUS_WIDTH'($urandom_range(0, 8191));
            default: s.vbus = VBUS_WIDTH'(int'(cfg_model.vbus_present_mv) +
                                          int'($urandom_range(0, 8)) - 4);
        endcase
        s.rc = 2'($urandom_range(0, 3));
        return s;
    endfunction

    task automatic push_sample(input t_power_sample s, input bit typed, input t_status want);
        bit      accepted;
        t_status model_out;
        in_if.valid             <= 1'b1;
        in_if.battery_mv        <= s.mv;
        in_if.battery_level     <= s.level;
        in_if.vbus_mv           <= s.vbus;
        in_if.reported_charging <= s.rc;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge i_clk);
            accepted = in_if.ready;
            @(posedge i_clk);
        end
        model_out = predict_status(s);
        pending_status.push_back(typed ? want : model_out);
    endtask

    task automatic idle_cycles(input int n);
        in_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic drive_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            bctd_pkg::REG_TREND_THRESHOLD:
                cfg_model.trend_threshold_mv = data[THR_WIDTH-1:0];
            bctd_pkg::REG_CONFIRM_SAMPLES:
                cfg_model.confirm_samples = data[COUNT_WIDTH-1:0];
            bctd_pkg::REG_CLEAR_SAMPLES:
                cfg_model.clear_samples = data[COUNT_WIDTH-1:0];
            bctd_pkg::REG_VBUS_PRESENT:
                cfg_model.vbus_present_mv = data[VP_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input bctd_pkg::t_cfg c, input int count, input t_seq_mode mode,
                             input int hold_cycles, input bit pause_mid);
        wait_drain();
        drive_reg(bctd_pkg::REG_TREND_THRESHOLD, CFG_WIDTH'(c.trend_threshold_mv));
        drive_reg(bctd_pkg::REG_CONFIRM_SAMPLES, CFG_WIDTH'(c.confirm_samples));
        drive_reg(bctd_pkg::REG_CLEAR_SAMPLES, CFG_WIDTH'(c.clear_samples));
        drive_reg(bctd_pkg::REG_VBUS_PRESENT, CFG_WIDTH'(c.vbus_present_mv));
        i_cfg_we <= 1'b0;
        if (mode == SEQ_RISE) cur_mv = 200;
        if (mode == SEQ_FALL) cur_mv = 8150;
        hold_request = hold_cycles;
        for (int k = 0; k < count; k++) begin
            if (pause_mid && k == count / 2) wait_drain();
            if (idle_on && $urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 16));
            push_sample(next_sample(mode), 1'b0, '0);
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0 && idle_on) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin : result_check
        t_status got;
        t_status want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.filt   = out_if.filtered_charging;
                got.disp   = out_if.level_displayable;
                got.tvalid = out_if.trend_valid;
                got.rise   = out_if.trend_rise_mv;
                got.dvalid = out_if.level_delta_valid;
                got.change = out_if.level_change;
                if (pending_status.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: %p", got);
                end else begin
                    want = pending_status.pop_front();
                    if (got.filt !== want.filt || got.disp !== want.disp ||
                        got.tvalid !== want.tvalid || got.rise !== want.rise ||
                        got.dvalid !== want.dvalid || got.change !== want.change) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch at %0t: exp %p got %p", $realtime, want, got);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        bctd_pkg::t_cfg c;
        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_idx               <= '0;
        i_cfg_data              <= '0;
        in_if.valid             <= 1'b0;
        in_if.battery_mv        <= '0;
        in_if.battery_level     <= '0;
        in_if.vbus_mv           <= '0;
        in_if.reported_charging <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (idle_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 16));
            push_sample(directed_rows[k].s, directed_rows[k].typed, directed_rows[k].want);
        end

        // long rise drives the above-threshold run into saturation, then a short fall
        c = '{10'd0, 8'd255, 8'd255, 13'd0};
        run_phase(c, 275, SEQ_RISE, 0, 1'b0);
        c = '{10'd1023, 8'd1, 8'd255, 13'd8191};
        run_phase(c, 50, SEQ_FALL, 0, 1'b0);

        // zero sample counts, with the result side held off
        c = '{10'd5, 8'd0, 8'd0, 13'd4000};
        run_phase(c, 50, SEQ_MIXED, 150, 1'b0);

        for (int p = 0; p < 3; p++) begin
            c.trend_threshold_mv = THR_WIDTH'($urandom_range(0, 60));
            c.confirm_samples    = COUNT_WIDTH'($urandom_range(1, 5));
            c.clear_samples      = COUNT_WIDTH'($urandom_range(1, 5));
            c.vbus_present_mv    = VP_WIDTH'($urandom_range(0, 8191));
            run_phase(c, 40, SEQ_MIXED, 0, p == 0);
        end

        idle_on = 1'b0;
        c = '{bctd_pkg::RST_TREND_THRESHOLD, bctd_pkg::RST_CONFIRM_SAMPLES,
              bctd_pkg::RST_CLEAR_SAMPLES, bctd_pkg::RST_VBUS_PRESENT};
        run_phase(c, 50, SEQ_MIXED, 0, 1'b0);

        wait_drain();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && pending_status.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
